[src/qlm_pkg.sv]
package qlm_pkg;

  localparam int ACT_W     = 2;
  localparam int TS_W      = 32;
  localparam int BYTES_W   = 32;
  localparam int QD_W      = 16;
  localparam int CNT_W     = 32;
  localparam int SUM_W     = 64;
  localparam int TRK_W     = 9;
  localparam int DIV_STEPS = 64;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_DETACH = 2'd2,
    ACT_REPORT = 2'd3
  } action_t;

  // commands from controller to datapath
  typedef struct packed {
    logic do_enq;
    logic do_deq;
    logic do_detach;
    logic do_report;
    logic div_step;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic age_busy;
  } dp_status_t;

endpackage

[src/queue_latency_monitor_core.sv]
// queue latency monitor: enqueue, dequeue and detach beats are never stalled and may
//   arrive back to back; a popped stamp is read, its age formed, then summed
// a report beat snapshots the window, then the 64-step restoring divider forms the average;
//   the result beat shows up when the divider is done and holds until accepted
// a report is stalled while the divider or the result slot is busy or an age is in flight
// synchronous active-low reset clears pointers, tracking and counters; the ring is not cleared
module queue_latency_monitor_core #(
  parameter int RING_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // event channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [qlm_pkg::ACT_W-1:0]          in_action,
  input  logic [qlm_pkg::TS_W-1:0]           in_now_us,
  input  logic signed [qlm_pkg::BYTES_W-1:0] in_frame_bytes,
  input  logic [qlm_pkg::QD_W-1:0]           in_queue_depth,
  // report channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [qlm_pkg::CNT_W-1:0]          out_enq_frame_cnt,
  output logic [qlm_pkg::SUM_W-1:0]          out_enq_byte_sum,
  output logic [qlm_pkg::CNT_W-1:0]          out_deq_frame_cnt,
  output logic [qlm_pkg::SUM_W-1:0]          out_deq_byte_sum,
  output logic [qlm_pkg::CNT_W-1:0]          out_age_count,
  output logic [qlm_pkg::TS_W-1:0]           out_age_average_us,
  output logic [qlm_pkg::TS_W-1:0]           out_age_peak_us,
  output logic [qlm_pkg::QD_W-1:0]           out_peak_depth,
  output logic [qlm_pkg::TRK_W-1:0]          out_tracked_frames,
  output logic                               out_age_tracking_valid,
  output logic [qlm_pkg::CNT_W-1:0]          out_overflow_count,
  output logic [qlm_pkg::CNT_W-1:0]          out_desync_count
);
  import qlm_pkg::*;

  // controller decodes accepted beats into datapath commands and sequences the divider
  dp_cmd_t    cmd;
  dp_status_t status;

  qlm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath holds the timestamp ring, window counters, age pipeline,
  // divider and the result slot
  qlm_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .in_now_us              (in_now_us),
    .in_frame_bytes         (in_frame_bytes),
    .in_queue_depth         (in_queue_depth),
    .out_enq_frame_cnt      (out_enq_frame_cnt),
    .out_enq_byte_sum       (out_enq_byte_sum),
    .out_deq_frame_cnt      (out_deq_frame_cnt),
    .out_deq_byte_sum       (out_deq_byte_sum),
    .out_age_count          (out_age_count),
    .out_age_average_us     (out_age_average_us),
    .out_age_peak_us        (out_age_peak_us),
    .out_peak_depth         (out_peak_depth),
    .out_tracked_frames     (out_tracked_frames),
    .out_age_tracking_valid (out_age_tracking_valid),
    .out_overflow_count     (out_overflow_count),
    .out_desync_count       (out_desync_count)
  );

endmodule

[src/qlm_ram.sv]
module qlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/qlm_ctrl.sv]
module qlm_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [qlm_pkg::ACT_W-1:0] in_action,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  qlm_pkg::dp_status_t       status,
  output qlm_pkg::dp_cmd_t          cmd
);
  import qlm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FULL = 3'b100
  } ctrl_state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  action_t           act;
  logic              accept;

  assign act = action_t'(in_action);

  // a report waits for the divider, the output slot and the age pipeline
  assign in_stall  = (act == ACT_REPORT) && ((state_r != S_IDLE) || status.age_busy);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state_r == S_FULL);

  always_comb begin
    cmd = '0;
    cmd.div_step = (state_r == S_DIV);
    if (accept) begin
      case (act)
        ACT_ENQ:    cmd.do_enq    = 1'b1;
        ACT_DEQ:    cmd.do_deq    = 1'b1;
        ACT_DETACH: cmd.do_detach = 1'b1;
        ACT_REPORT: cmd.do_report = 1'b1;
        default:    cmd.do_enq    = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.do_report) begin
          state_nxt = S_DIV;
          step_nxt  = '0;
        end
      end
      S_DIV: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_FULL;
        end
      end
      S_FULL: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

`ifndef SYNTH
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r == LAST_STEP) |=> (state_r == S_FULL))
    else $error("divider did not finish into the output slot");

  a_report_after_ages: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_report |-> !status.age_busy)
    else $error("report taken with an age still in flight");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without a handshake");
`endif

endmodule

[src/qlm_dp.sv]
module qlm_dp #(
  parameter int RING_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  qlm_pkg::dp_cmd_t             cmd,
  output qlm_pkg::dp_status_t          status,
  input  logic [qlm_pkg::TS_W-1:0]     in_now_us,
  input  logic signed [qlm_pkg::BYTES_W-1:0] in_frame_bytes,
  input  logic [qlm_pkg::QD_W-1:0]     in_queue_depth,
  output logic [qlm_pkg::CNT_W-1:0]    out_enq_frame_cnt,
  output logic [qlm_pkg::SUM_W-1:0]    out_enq_byte_sum,
  output logic [qlm_pkg::CNT_W-1:0]    out_deq_frame_cnt,
  output logic [qlm_pkg::SUM_W-1:0]    out_deq_byte_sum,
  output logic [qlm_pkg::CNT_W-1:0]    out_age_count,
  output logic [qlm_pkg::TS_W-1:0]     out_age_average_us,
  output logic [qlm_pkg::TS_W-1:0]     out_age_peak_us,
  output logic [qlm_pkg::QD_W-1:0]     out_peak_depth,
  output logic [qlm_pkg::TRK_W-1:0]    out_tracked_frames,
  output logic                         out_age_tracking_valid,
  output logic [qlm_pkg::CNT_W-1:0]    out_overflow_count,
  output logic [qlm_pkg::CNT_W-1:0]    out_desync_count
);
  import qlm_pkg::*;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int RCNT_W = $clog2(RING_DEPTH + 1);
  localparam int TSUM_W = RCNT_W + 1;

  // ring control
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [RCNT_W-1:0] count_r, count_nxt;
  logic              lost_r, lost_nxt;

  // window statistics
  logic [CNT_W-1:0] enq_frames_r, enq_frames_nxt;
  logic [SUM_W-1:0] enq_bytes_r, enq_bytes_nxt;
  logic [CNT_W-1:0] deq_frames_r, deq_frames_nxt;
  logic [SUM_W-1:0] deq_bytes_r, deq_bytes_nxt;
  logic [SUM_W-1:0] age_sum_r, age_sum_nxt;
  logic [CNT_W-1:0] age_samples_r, age_samples_nxt;
  logic [TS_W-1:0]  age_max_r, age_max_nxt;
  logic [QD_W-1:0]  depth_max_r, depth_max_nxt;
  logic [CNT_W-1:0] overflows_r, overflows_nxt;
  logic [CNT_W-1:0] desyncs_r, desyncs_nxt;

  // age pipeline: ring read, then subtract, then accumulate
  logic            pend_r, pend_nxt;
  logic [TS_W-1:0] pend_now_r, pend_now_nxt;
  logic            age_vld_r, age_vld_nxt;
  logic [TS_W-1:0] age_r, age_nxt;

  // result slot
  logic [CNT_W-1:0] o_enq_frames_r, o_enq_frames_nxt;
  logic [SUM_W-1:0] o_enq_bytes_r, o_enq_bytes_nxt;
  logic [CNT_W-1:0] o_deq_frames_r, o_deq_frames_nxt;
  logic [SUM_W-1:0] o_deq_bytes_r, o_deq_bytes_nxt;
  logic [CNT_W-1:0] o_samples_r, o_samples_nxt;
  logic [TS_W-1:0]  o_age_max_r, o_age_max_nxt;
  logic [QD_W-1:0]  o_depth_r, o_depth_nxt;
  logic [TRK_W-1:0] o_tracked_r, o_tracked_nxt;
  logic             o_valid_trk_r, o_valid_trk_nxt;
  logic [CNT_W-1:0] o_overflows_r, o_overflows_nxt;
  logic [CNT_W-1:0] o_desyncs_r, o_desyncs_nxt;

  // restoring divider, one quotient bit a step
  logic [TS_W-1:0]  div_rem_r, div_rem_nxt;
  logic [SUM_W-1:0] div_quo_r, div_quo_nxt;
  logic [CNT_W-1:0] div_den_r, div_den_nxt;
  logic             div_zero_r, div_zero_nxt;
  logic [TS_W:0]    div_shift;
  logic             div_ge;

  logic [BYTES_W-1:0] bytes_raw;
  logic [BYTES_W-1:0] bytes_u;
  logic [QD_W-1:0]    depth_after;
  logic               deq_live;
  logic               deq_hit;
  logic               ring_room;
  logic               ram_we;
  logic [TSUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   head_inc;
  logic [TS_W-1:0]    ram_rdata;

  assign bytes_raw   = in_frame_bytes;
  assign bytes_u     = bytes_raw[BYTES_W-1] ? '0 : bytes_raw;
  assign depth_after = (in_queue_depth == '1) ? '1 : in_queue_depth + 1'b1;
  assign deq_live    = cmd.do_deq && (in_queue_depth != '0);
  assign deq_hit     = deq_live && !lost_r && (count_r != '0);
  assign ring_room   = count_r < RCNT_W'(RING_DEPTH);
  assign ram_we      = cmd.do_enq && !lost_r && ring_room;

  assign tail_sum = TSUM_W'(head_r) + TSUM_W'(count_r);
  assign tail     = (tail_sum >= TSUM_W'(RING_DEPTH)) ?
                    PTR_W'(tail_sum - TSUM_W'(RING_DEPTH)) : PTR_W'(tail_sum);
  assign head_inc = (head_r == PTR_W'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;

  assign div_shift = {div_rem_r, div_quo_r[SUM_W-1]};
  assign div_ge    = div_shift >= (TS_W + 1)'(div_den_r);

  assign status.age_busy = pend_r || age_vld_r;

  qlm_ram #(
    .WIDTH (TS_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (in_now_us),
    .re    (deq_hit),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    head_nxt        = head_r;
    count_nxt       = count_r;
    lost_nxt        = lost_r;
    enq_frames_nxt  = enq_frames_r;
    enq_bytes_nxt   = enq_bytes_r;
    deq_frames_nxt  = deq_frames_r;
    deq_bytes_nxt   = deq_bytes_r;
    age_sum_nxt     = age_sum_r;
    age_samples_nxt = age_samples_r;
    age_max_nxt     = age_max_r;
    depth_max_nxt   = depth_max_r;
    overflows_nxt   = overflows_r;
    desyncs_nxt     = desyncs_r;

    pend_nxt     = deq_hit;
    pend_now_nxt = in_now_us;
    age_vld_nxt  = pend_r;
    age_nxt      = pend_now_r - ram_rdata;

    o_enq_frames_nxt = o_enq_frames_r;
    o_enq_bytes_nxt  = o_enq_bytes_r;
    o_deq_frames_nxt = o_deq_frames_r;
    o_deq_bytes_nxt  = o_deq_bytes_r;
    o_samples_nxt    = o_samples_r;
    o_age_max_nxt    = o_age_max_r;
    o_depth_nxt      = o_depth_r;
    o_tracked_nxt    = o_tracked_r;
    o_valid_trk_nxt  = o_valid_trk_r;
    o_overflows_nxt  = o_overflows_r;
    o_desyncs_nxt    = o_desyncs_r;

    div_rem_nxt  = div_rem_r;
    div_quo_nxt  = div_quo_r;
    div_den_nxt  = div_den_r;
    div_zero_nxt = div_zero_r;

    if (age_vld_r) begin
      age_samples_nxt = age_samples_r + 1'b1;
      age_sum_nxt     = age_sum_r + SUM_W'(age_r);
      if (age_r > age_max_r) begin
        age_max_nxt = age_r;
      end
    end

    if (cmd.do_enq) begin
      enq_frames_nxt = enq_frames_r + 1'b1;
      enq_bytes_nxt  = enq_bytes_r + SUM_W'(bytes_u);
      if (!lost_r) begin
        if (ring_room) begin
          count_nxt = count_r + 1'b1;
        end else begin
          overflows_nxt = overflows_r + 1'b1;
          lost_nxt      = 1'b1;
          head_nxt      = '0;
          count_nxt     = '0;
        end
      end
      if (depth_after > depth_max_r) begin
        depth_max_nxt = depth_after;
      end
    end

    if (deq_live) begin
      if (deq_hit) begin
        head_nxt  = head_inc;
        count_nxt = count_r - 1'b1;
      end else if (!lost_r) begin
        desyncs_nxt = desyncs_r + 1'b1;
      end
      deq_frames_nxt = deq_frames_r + 1'b1;
      deq_bytes_nxt  = deq_bytes_r + SUM_W'(bytes_u);
      // queue drained while untracked: start over
      if ((in_queue_depth == QD_W'(1)) && lost_r) begin
        lost_nxt  = 1'b0;
        head_nxt  = '0;
        count_nxt = '0;
      end
    end

    if (cmd.do_detach) begin
      lost_nxt  = 1'b0;
      head_nxt  = '0;
      count_nxt = '0;
    end

    if (cmd.div_step) begin
      div_rem_nxt = div_ge ? TS_W'(div_shift - (TS_W + 1)'(div_den_r)) : div_shift[TS_W-1:0];
      div_quo_nxt = {div_quo_r[SUM_W-2:0], div_ge};
    end

    if (cmd.do_report) begin
      o_enq_frames_nxt = enq_frames_r;
      o_enq_bytes_nxt  = enq_bytes_r;
      o_deq_frames_nxt = deq_frames_r;
      o_deq_bytes_nxt  = deq_bytes_r;
      o_samples_nxt    = age_samples_r;
      o_age_max_nxt    = age_max_r;
      o_depth_nxt      = depth_max_r;
      o_tracked_nxt    = TRK_W'(count_r);
      o_valid_trk_nxt  = !lost_r;
      o_overflows_nxt  = overflows_r;
      o_desyncs_nxt    = desyncs_r;

      div_rem_nxt  = '0;
      div_quo_nxt  = age_sum_r;
      div_den_nxt  = age_samples_r;
      div_zero_nxt = (age_samples_r == '0);

      enq_frames_nxt  = '0;
      enq_bytes_nxt   = '0;
      deq_frames_nxt  = '0;
      deq_bytes_nxt   = '0;
      age_sum_nxt     = '0;
      age_samples_nxt = '0;
      age_max_nxt     = '0;
      depth_max_nxt   = in_queue_depth;
      overflows_nxt   = '0;
      desyncs_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      count_r       <= '0;
      lost_r        <= 1'b0;
      enq_frames_r  <= '0;
      enq_bytes_r   <= '0;
      deq_frames_r  <= '0;
      deq_bytes_r   <= '0;
      age_sum_r     <= '0;
      age_samples_r <= '0;
      age_max_r     <= '0;
      depth_max_r   <= '0;
      overflows_r   <= '0;
      desyncs_r     <= '0;
      pend_r        <= 1'b0;
      age_vld_r     <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      lost_r        <= lost_nxt;
      enq_frames_r  <= enq_frames_nxt;
      enq_bytes_r   <= enq_bytes_nxt;
      deq_frames_r  <= deq_frames_nxt;
      deq_bytes_r   <= deq_bytes_nxt;
      age_sum_r     <= age_sum_nxt;
      age_samples_r <= age_samples_nxt;
      age_max_r     <= age_max_nxt;
      depth_max_r   <= depth_max_nxt;
      overflows_r   <= overflows_nxt;
      desyncs_r     <= desyncs_nxt;
      pend_r        <= pend_nxt;
      age_vld_r     <= age_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_now_r     <= pend_now_nxt;
    age_r          <= age_nxt;
    o_enq_frames_r <= o_enq_frames_nxt;
    o_enq_bytes_r  <= o_enq_bytes_nxt;
    o_deq_frames_r <= o_deq_frames_nxt;
    o_deq_bytes_r  <= o_deq_bytes_nxt;
    o_samples_r    <= o_samples_nxt;
    o_age_max_r    <= o_age_max_nxt;
    o_depth_r      <= o_depth_nxt;
    o_tracked_r    <= o_tracked_nxt;
    o_valid_trk_r  <= o_valid_trk_nxt;
    o_overflows_r  <= o_overflows_nxt;
    o_desyncs_r    <= o_desyncs_nxt;
    div_rem_r      <= div_rem_nxt;
    div_quo_r      <= div_quo_nxt;
    div_den_r      <= div_den_nxt;
    div_zero_r     <= div_zero_nxt;
  end

  assign out_enq_frame_cnt      = o_enq_frames_r;
  assign out_enq_byte_sum       = o_enq_bytes_r;
  assign out_deq_frame_cnt      = o_deq_frames_r;
  assign out_deq_byte_sum       = o_deq_bytes_r;
  assign out_age_count          = o_samples_r;
  assign out_age_average_us     = div_zero_r ? '0 : div_quo_r[TS_W-1:0];
  assign out_age_peak_us        = o_age_max_r;
  assign out_peak_depth         = o_depth_r;
  assign out_tracked_frames     = o_tracked_r;
  assign out_age_tracking_valid = o_valid_trk_r;
  assign out_overflow_count     = o_overflows_r;
  assign out_desync_count       = o_desyncs_r;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RCNT_W'(RING_DEPTH))
    else $error("ring count beyond ring depth");

  a_lost_empty: assert property (@(posedge clk) disable iff (!rst_n)
    lost_r |-> (count_r == '0))
    else $error("ring holds entries while tracking is lost");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ($past(count_r) != '0))
    else $error("ring read issued on an empty ring");
`endif

endmodule

[sim/tb_top.sv]
module tb_top;
  import qlm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RING_SLOTS     = 256;
  localparam int PHASE_ITEMS    = 550;
  localparam int DRAIN_CYCLES   = 120;
  localparam int HOLD_AT_REPORT = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int TIMEOUT_CYCLES = 1000000;

  typedef struct packed {
    action_t                   act;
    logic [TS_W-1:0]           now;
    logic signed [BYTES_W-1:0] bytes;
    logic [QD_W-1:0]           depth;
  } queue_event_t;

  typedef struct packed {
    logic [CNT_W-1:0] enq_frames;
    logic [SUM_W-1:0] enq_bytes;
    logic [CNT_W-1:0] deq_frames;
    logic [SUM_W-1:0] deq_bytes;
    logic [CNT_W-1:0] age_cnt;
    logic [TS_W-1:0]  age_avg;
    logic [TS_W-1:0]  age_peak;
    logic [QD_W-1:0]  depth_peak;
    logic [TRK_W-1:0] tracked;
    logic             trk_valid;
    logic [CNT_W-1:0] ovf_cnt;
    logic [CNT_W-1:0] desync_cnt;
  } window_report_t;

  typedef struct packed {
    queue_event_t   ev;
    logic           typed_in;
    window_report_t want;
  } directed_row_t;

  // reports whose value is plain from the events before them
  localparam window_report_t NO_RPT    = '0;
  localparam window_report_t RPT_RESET = '{trk_valid: 1'b1, default: '0};
  localparam window_report_t RPT_MIXED = '{
    enq_frames: 32'd2, enq_bytes: 64'h7FFF_FFFF, deq_frames: 32'd3, deq_bytes: 64'd17,
    age_cnt: 32'd2, age_avg: 32'd116, age_peak: 32'd200, depth_peak: 16'hFFFF,
    tracked: 9'd0, trk_valid: 1'b1, ovf_cnt: 32'd0, desync_cnt: 32'd1};
  localparam window_report_t RPT_DETACH = '{
    enq_frames: 32'd2, enq_bytes: 64'd65, deq_frames: 32'd1, deq_bytes: 64'd0,
    age_cnt: 32'd0, age_avg: 32'd0, age_peak: 32'd0, depth_peak: 16'd8,
    tracked: 9'd1, trk_valid: 1'b1, ovf_cnt: 32'd0, desync_cnt: 32'd1};
  localparam window_report_t RPT_HELD = '{depth_peak: 16'hFFFF, trk_valid: 1'b1, default: '0};

  localparam int DIR_ROWS = 20;
  localparam directed_row_t DIR_TAB [DIR_ROWS] = '{
    //   action       now_us         frame_bytes      depth      typed  report
    '{'{ACT_REPORT, 32'd0,         32'sd0,          16'd0},    1'b1, RPT_RESET},
    '{'{ACT_ENQ,    32'd100,       -32'sd1,         16'd0},    1'b0, NO_RPT},
    '{'{ACT_ENQ,    32'hFFFF_FFF0, 32'sh7FFF_FFFF,  16'hFFFF}, 1'b0, NO_RPT},
    '{'{ACT_DEQ,    32'd500,       32'sd1000,       16'd0},    1'b0, NO_RPT},
    '{'{ACT_DEQ,    32'd300,       32'sd10,         16'd2},    1'b0, NO_RPT},
    '{'{ACT_DEQ,    32'h0000_0010, 32'sh8000_0000,  16'd1},    1'b0, NO_RPT},
    '{'{ACT_DEQ,    32'd5,         32'sd7,          16'd3},    1'b0, NO_RPT},
    '{'{ACT_REPORT, 32'd6,         32'sd0,          16'd7},    1'b1, RPT_MIXED},
    '{'{ACT_ENQ,    32'd1000,      32'sd64,         16'd7},    1'b0, NO_RPT},
    '{'{ACT_DETACH, 32'd0,         -32'sd5,         16'd8},    1'b0, NO_RPT},
    '{'{ACT_DEQ,    32'd1200,      32'sd0,          16'd8},    1'b0, NO_RPT},
    '{'{ACT_ENQ,    32'hFFFF_FFFF, 32'sd1,          16'd7},    1'b0, NO_RPT},
    '{'{ACT_REPORT, 32'd1300,      32'sd0,          16'd7},    1'b1, RPT_DETACH},
    '{'{ACT_DEQ,    32'd0,         32'sh7FFF_FFFF,  16'hFFFF}, 1'b0, NO_RPT},
    '{'{ACT_ENQ,    32'hAAAA_AAAA, 32'sh5555_5555,  16'hAAAA}, 1'b0, NO_RPT},
    '{'{ACT_ENQ,    32'h5555_5555, 32'sh2AAA_AAAA,  16'h5555}, 1'b0, NO_RPT},
    '{'{ACT_DEQ,    32'hFFFF_FFFF, 32'shAAAA_AAAA,  16'h5556}, 1'b0, NO_RPT},
    '{'{ACT_DEQ,    32'h5555_5554, 32'sd1,          16'd2},    1'b0, NO_RPT},
    '{'{ACT_REPORT, 32'd2000,      32'sd0,          16'hFFFF}, 1'b0, NO_RPT},
    '{'{ACT_REPORT, 32'd2001,      32'sd0,          16'd0},    1'b1, RPT_HELD}
  };

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      in_valid       = 1'b0;
  logic                      in_stall;
  logic [ACT_W-1:0]          in_action      = ACT_ENQ;
  logic [TS_W-1:0]           in_now_us      = '0;
  logic signed [BYTES_W-1:0] in_frame_bytes = '0;
  logic [QD_W-1:0]           in_queue_depth = '0;
  logic                      out_valid;
  logic                      out_stall      = 1'b0;
  logic [CNT_W-1:0]          out_enq_frame_cnt;
  logic [SUM_W-1:0]          out_enq_byte_sum;
  logic [CNT_W-1:0]          out_deq_frame_cnt;
  logic [SUM_W-1:0]          out_deq_byte_sum;
  logic [CNT_W-1:0]          out_age_count;
  logic [TS_W-1:0]           out_age_average_us;
  logic [TS_W-1:0]           out_age_peak_us;
  logic [QD_W-1:0]           out_peak_depth;
  logic [TRK_W-1:0]          out_tracked_frames;
  logic                      out_age_tracking_valid;
  logic [CNT_W-1:0]          out_overflow_count;
  logic [CNT_W-1:0]          out_desync_count;

  queue_latency_monitor_core #(.RING_DEPTH(RING_SLOTS)) u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_now_us              (in_now_us),
    .in_frame_bytes         (in_frame_bytes),
    .in_queue_depth         (in_queue_depth),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_enq_frame_cnt      (out_enq_frame_cnt),
    .out_enq_byte_sum       (out_enq_byte_sum),
    .out_deq_frame_cnt      (out_deq_frame_cnt),
    .out_deq_byte_sum       (out_deq_byte_sum),
    .out_age_count          (out_age_count),
    .out_age_average_us     (out_age_average_us),
    .out_age_peak_us        (out_age_peak_us),
    .out_peak_depth         (out_peak_depth),
    .out_tracked_frames     (out_tracked_frames),
    .out_age_tracking_valid (out_age_tracking_valid),
    .out_overflow_count     (out_overflow_count),
    .out_desync_count       (out_desync_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // expected report beats, oldest first
  window_report_t pending_reports[$];
  int unsigned    fail_count   = 0;
  int unsigned    reports_seen = 0;
  int unsigned    items_done   = 0;
  int unsigned    tx_idle_pct  = 8;
  int unsigned    rx_idle_pct  = 47;

  // mirror of the monitor state
  logic [TS_W-1:0]  stamp_ring [RING_SLOTS];
  int unsigned      ring_rd    = 0;
  int unsigned      ring_fill  = 0;
  logic             track_lost = 1'b0;
  logic [CNT_W-1:0] enq_n      = '0;
  logic [SUM_W-1:0] enq_sum    = '0;
  logic [CNT_W-1:0] deq_n      = '0;
  logic [SUM_W-1:0] deq_sum    = '0;
  logic [SUM_W-1:0] age_sum    = '0;
  logic [CNT_W-1:0] age_n      = '0;
  logic [TS_W-1:0]  age_hi     = '0;
  logic [QD_W-1:0]  depth_hi   = '0;
  logic [CNT_W-1:0] ovf_n      = '0;
  logic [CNT_W-1:0] desync_n   = '0;

  // model of the real queue behind the random traffic
  logic [TS_W-1:0] clock_us   = '0;
  int unsigned     live_depth = 0;

  function automatic void predict_window(input queue_event_t ev, output logic has_rpt,
                                         output window_report_t rpt);
    logic [31:0]     len;
    logic [QD_W-1:0] after;
    logic [TS_W-1:0] age;
    len     = ev.bytes[BYTES_W-1] ? '0 : ev.bytes;
    has_rpt = 1'b0;
    rpt     = '0;
    case (ev.act)
      ACT_ENQ: begin
        enq_n++;
        enq_sum += 64'(len);
        if (!track_lost && ring_fill < RING_SLOTS) begin
          stamp_ring[(ring_rd + ring_fill) % RING_SLOTS] = ev.now;
          ring_fill++;
        end else if (!track_lost) begin
          // ring full: give up on ages until the queue drains
          ovf_n++;
          track_lost = 1'b1;
          ring_rd    = 0;
          ring_fill  = 0;
        end
        after = (ev.depth == '1) ? ev.depth : ev.depth + 1'b1;
        if (after > depth_hi) depth_hi = after;
      end
      ACT_DEQ: begin
        if (ev.depth != '0) begin
          if (!track_lost && ring_fill != 0) begin
            age       = ev.now - stamp_ring[ring_rd];
            ring_rd   = (ring_rd + 1) % RING_SLOTS;
            ring_fill--;
            age_n++;
            age_sum += 64'(age);
            if (age > age_hi) age_hi = age;
          end else if (!track_lost) begin
            desync_n++;
          end
          deq_n++;
          deq_sum += 64'(len);
          // last frame leaving a lost queue restarts tracking
          if (ev.depth == 16'd1 && track_lost) begin
            track_lost = 1'b0;
            ring_rd    = 0;
            ring_fill  = 0;
          end
        end
      end
      ACT_DETACH: begin
        ring_rd    = 0;
        ring_fill  = 0;
        track_lost = 1'b0;
      end
      ACT_REPORT: begin
        has_rpt        = 1'b1;
        rpt.enq_frames = enq_n;
        rpt.enq_bytes  = enq_sum;
        rpt.deq_frames = deq_n;
        rpt.deq_bytes  = deq_sum;
        rpt.age_cnt    = age_n;
        rpt.age_avg    = (age_n != '0) ? TS_W'(age_sum / 64'(age_n)) : '0;
        rpt.age_peak   = age_hi;
        rpt.depth_peak = depth_hi;
        rpt.tracked    = TRK_W'(ring_fill);
        rpt.trk_valid  = !track_lost;
        rpt.ovf_cnt    = ovf_n;
        rpt.desync_cnt = desync_n;
        enq_n    = '0;
        enq_sum  = '0;
        deq_n    = '0;
        deq_sum  = '0;
        age_sum  = '0;
        age_n    = '0;
        age_hi   = '0;
        ovf_n    = '0;
        desync_n = '0;
        depth_hi = ev.depth;
      end
      default: has_rpt = 1'b0;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_event(input queue_event_t ev, input logic typed_in = 1'b0,
                            input window_report_t typed = '0);
    logic           has_rpt;
    window_report_t rpt;
    in_valid       <= 1'b1;
    in_action      <= ev.act;
    in_now_us      <= ev.now;
    in_frame_bytes <= ev.bytes;
    in_queue_depth <= ev.depth;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_window(ev, has_rpt, rpt);
    if (has_rpt) pending_reports.push_back(typed_in ? typed : rpt);
    @(negedge clk);
  endtask

  task automatic idle_sender();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic rest_until_drained();
    in_valid <= 1'b0;
    wait (pending_reports.size() == 0);
    @(negedge clk);
  endtask

  task automatic offer(action_t act, logic [TS_W-1:0] stamp, int unsigned depth);
    queue_event_t ev;
    ev.act   = act;
    ev.now   = stamp;
    ev.depth = QD_W'(depth);
    ev.bytes = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 1514);
    idle_sender();
    send_event(ev);
    // a dequeue from an empty queue is dropped by the block
    if (!(act == ACT_DEQ && ev.depth == '0)) items_done++;
  endtask

  // one well-formed queue event, sometimes preceded by a report or a detach
  task automatic queue_step(logic is_enq);
    int unsigned roll;
    roll = $urandom_range(99);
    clock_us += $urandom_range(0, 3000);
    if (roll < 4) offer(ACT_REPORT, clock_us, live_depth);
    else if (roll == 4) offer(ACT_DETACH, clock_us, live_depth);
    if (is_enq) begin
      offer(ACT_ENQ, clock_us, live_depth);
      if (live_depth < 65535) live_depth++;
    end else begin
      offer(ACT_DEQ, clock_us, live_depth);
      if (live_depth != 0) live_depth--;
    end
  endtask

  task automatic run_traffic(int unsigned quota);
    int unsigned goal;
    int unsigned roll;
    int unsigned k;
    goal = items_done + quota;
    while (items_done < goal) begin
      roll = $urandom_range(99);
      // park the clock just below its wrap now and then
      if ($urandom_range(7) == 0) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 40000);
      if (roll < 65) begin
        // fill then drain; big fills run the ring over
        k = ($urandom_range(4) == 0) ? $urandom_range(250, 300) : $urandom_range(1, 24);
        repeat (k) queue_step(1'b1);
        k = ($urandom_range(1) == 0) ? live_depth : $urandom_range(0, live_depth);
        repeat (k) queue_step(1'b0);
      end else if (roll < 90) begin
        repeat (20) queue_step($urandom_range(1));
      end else begin
        // noise that ignores the queue model
        repeat ($urandom_range(1, 5))
          offer(action_t'($urandom_range(3)), $urandom, $urandom_range(0, 65535));
      end
    end
  endtask

  task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // report beat checker
  always @(posedge clk) begin : report_check
    window_report_t want;
    if (rst_n && $isunknown(out_valid)) begin
      $display("%0t: out_valid unknown", $time);
      fail_count++;
    end else if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report beat with nothing expected, enq_frame_cnt 0x%0h", $time,
                 out_enq_frame_cnt);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("enq_frame_cnt", want.enq_frames, out_enq_frame_cnt);
        check_field("enq_byte_sum", want.enq_bytes, out_enq_byte_sum);
        check_field("deq_frame_cnt", want.deq_frames, out_deq_frame_cnt);
        check_field("deq_byte_sum", want.deq_bytes, out_deq_byte_sum);
        check_field("age_count", want.age_cnt, out_age_count);
        check_field("age_average_us", want.age_avg, out_age_average_us);
        check_field("age_peak_us", want.age_peak, out_age_peak_us);
        check_field("peak_depth", want.depth_peak, out_peak_depth);
        check_field("tracked_frames", want.tracked, out_tracked_frames);
        check_field("age_tracking_valid", want.trk_valid, out_age_tracking_valid);
        check_field("overflow_count", want.ovf_cnt, out_overflow_count);
        check_field("desync_count", want.desync_cnt, out_desync_count);
      end
      reports_seen++;
    end
  end

  // report receiver: random stalls, plus one long hold-off so the block backs up
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && reports_seen == HOLD_AT_REPORT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (DIR_TAB[i]) begin
      idle_sender();
      send_event(DIR_TAB[i].ev, DIR_TAB[i].typed_in, DIR_TAB[i].want);
    end
    rest_until_drained();
    clock_us = $urandom;
    run_traffic(PHASE_ITEMS);
    rest_until_drained();
    tx_idle_pct = 47;
    rx_idle_pct = 8;
    run_traffic(PHASE_ITEMS);
    rest_until_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_traffic(PHASE_ITEMS);
    rest_until_drained();
    // room for a stray late beat to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("queue_latency_monitor_core regression: pass");
    end else begin
      $display("queue_latency_monitor_core regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: run timed out, %0d reports outstanding", $time, pending_reports.size());
    $display("queue_latency_monitor_core regression: fail");
    $finish;
  end

endmodule
